/* src/ilh_pkg.sv */
// Shared types and codes of the indexed lexicographic priority heap.
// Used by the key saturator, the memory wrapper and the top level; depends on nothing.
`timescale 1ns / 1ps
package ilh_pkg;

	localparam int ELEM_W = 10;
	localparam int COST_W = 32;
	localparam int COUNT_OUT_W = 11;

	typedef enum logic [1:0] {
		MODE_UPDATE = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_WRONG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_WHITE = 2'd0,
		MARK_GRAY  = 2'd1,
		MARK_BLACK = 2'd2
	} mark_t;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_CLR    = 12'b0000_0000_0010,
		S_LOOK   = 12'b0000_0000_0100,
		S_DECIDE = 12'b0000_0000_1000,
		S_DREAD  = 12'b0000_0001_0000,
		S_DCMP   = 12'b0000_0010_0000,
		S_UP     = 12'b0000_0100_0000,
		S_UPCMP  = 12'b0000_1000_0000,
		S_DOWN   = 12'b0001_0000_0000,
		S_DNSEL  = 12'b0010_0000_0000,
		S_DNSW   = 12'b0100_0000_0000,
		S_FIN    = 12'b1000_0000_0000
	} state_t;

endpackage

/* src/ilh_key_sat.sv */
// Saturates a signed 32-bit cost into the signed key width of the heap.
// Depends on ilh_pkg for the cost width.
`timescale 1ns / 1ps
module ilh_key_sat import ilh_pkg::*; #(
	parameter int KW = 32
) (
	input  logic signed [COST_W-1:0] cost,
	output logic signed [KW-1:0]     key
);
	localparam int XW = (KW > COST_W) ? KW : COST_W;

	logic signed [XW-1:0] x;
	logic signed [XW-1:0] hi;
	logic signed [XW-1:0] lo;
	logic signed [KW-1:0] kmax;
	logic signed [KW-1:0] kmin;

	assign kmax = {1'b0, {(KW-1){1'b1}}};
	assign kmin = {1'b1, {(KW-1){1'b0}}};
	assign x    = XW'(cost);
	assign hi   = XW'(kmax);
	assign lo   = XW'(kmin);

	always_comb begin
		if (x > hi) begin
			key = kmax;
		end else if (x < lo) begin
			key = kmin;
		end else begin
			key = KW'(x);
		end
	end
endmodule

/* src/ilh_mem.sv */
// Synchronous memories of the heap: slot entries with two read ports,
// the element-to-slot map and the element marks. Depends on ilh_pkg.
`timescale 1ns / 1ps
module ilh_mem import ilh_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int HW    = 74
) (
	input  logic          clk,
	input  logic          hp_we,
	input  logic [AW-1:0] hp_wa,
	input  logic [HW-1:0] hp_wd,
	input  logic [AW-1:0] hp_ra0,
	input  logic [AW-1:0] hp_ra1,
	output logic [HW-1:0] hp_rd0,
	output logic [HW-1:0] hp_rd1,
	input  logic          e2s_we,
	input  logic [AW-1:0] e2s_wa,
	input  logic [AW-1:0] e2s_wd,
	input  logic [AW-1:0] e2s_ra,
	output logic [AW-1:0] e2s_rd,
	input  logic          mk_we,
	input  logic [AW-1:0] mk_wa,
	input  mark_t         mk_wd,
	input  logic [AW-1:0] mk_ra,
	output mark_t         mk_rd
);
	logic [HW-1:0] hp_mem [DEPTH];
	logic [AW-1:0] e2s_mem [DEPTH];
	mark_t         mk_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (hp_we) begin
			hp_mem[hp_wa] <= hp_wd;
		end
		hp_rd0 <= hp_mem[hp_ra0];
		hp_rd1 <= hp_mem[hp_ra1];
	end

	always_ff @(posedge clk) begin
		if (e2s_we) begin
			e2s_mem[e2s_wa] <= e2s_wd;
		end
		e2s_rd <= e2s_mem[e2s_ra];
	end

	always_ff @(posedge clk) begin
		if (mk_we) begin
			mk_mem[mk_wa] <= mk_wd;
		end
		mk_rd <= mk_mem[mk_ra];
	end
endmodule

/* src/indexed_lex_priority_heap_core.sv */
// Top level of the indexed lexicographic priority heap: command sequencer and sift engine.
// Depends on ilh_pkg, ilh_key_sat and ilh_mem.
`timescale 1ns / 1ps
// One word in, one result word out per command. Heap entries live in a slot memory with two
// registered read ports, so each sift level is a read followed by a compare. Clear, and the
// pass that follows reset, rewrite the mark memory one element per cycle, and no word is
// accepted until that pass ends. A new word may be taken while the previous result still waits.
module indexed_lex_priority_heap_core import ilh_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int KEY_WIDTH    = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic                     cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic [ELEM_W-1:0]        element,
	input  logic signed [COST_W-1:0] cost_primary,
	input  logic signed [COST_W-1:0] cost_secondary,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ELEM_W-1:0]        removed_element,
	output logic [ELEM_W-1:0]        top_element,
	output logic                     top_valid,
	output logic                     heap_full,
	output logic [COUNT_OUT_W-1:0]   entry_count,
	output logic [1:0]               status
);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int KW = KEY_WIDTH;
	localparam int HW = ELEM_W + 2 * KW;
	localparam int LW = AW + 2;

	typedef struct packed {
		logic [ELEM_W-1:0] elem;
		logic signed [KW-1:0] kp;
		logic signed [KW-1:0] ks;
	} entry_t;

	function automatic logic ranks_first(input entry_t a, input entry_t b, input logic minp);
		if (minp) begin
			return (a.kp < b.kp) || ((a.kp == b.kp) && (a.ks < b.ks));
		end
		return (a.kp > b.kp) || ((a.kp == b.kp) && (a.ks > b.ks));
	endfunction

	state_t state_q;
	logic   min_policy_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] clr_q;
	logic   clr_op_q;
	mode_t  mode_q;
	logic [ELEM_W-1:0] elem_q;
	logic   in_range_q;
	logic signed [KW-1:0] kp_q;
	logic signed [KW-1:0] ks_q;
	entry_t cur_q;
	entry_t cdata_q;
	logic [AW-1:0] hole_q;
	logic [AW-1:0] child_q;
	logic [AW-1:0] left_q;
	logic [AW-1:0] right_q;
	logic   rvalid_q;
	logic [ELEM_W-1:0] top_q;
	logic [ELEM_W-1:0] removed_q;
	status_t status_q;

	logic   out_valid_q;
	logic [ELEM_W-1:0] out_removed_q;
	logic [ELEM_W-1:0] out_top_q;
	logic   out_top_valid_q;
	logic   out_full_q;
	logic [COUNT_OUT_W-1:0] out_count_q;
	status_t out_status_q;

	logic signed [KW-1:0] kp_sat;
	logic signed [KW-1:0] ks_sat;
	logic [AW-1:0] elem_idx;
	logic [AW:0]   left_w;
	logic [LW-1:0] right_w;
	logic   left_ok;
	logic   right_ok;
	logic [AW-1:0] parent;

	logic   hp_we;
	logic [AW-1:0] hp_wa;
	entry_t hp_wd;
	logic [AW-1:0] hp_ra0;
	logic [AW-1:0] hp_ra1;
	logic [HW-1:0] hp_rd0;
	logic [HW-1:0] hp_rd1;
	entry_t rd0_e;
	entry_t rd1_e;
	logic [AW-1:0] e2s_rd;
	logic   mk_we;
	logic [AW-1:0] mk_wa;
	mark_t  mk_wd;
	mark_t  mk_rd;
	logic   is_full;
	logic   up_move;
	logic   dn_move;
	logic   pick_right;
	logic   accept;

	ilh_key_sat #(.KW(KW)) u_sat_p (.cost(cost_primary), .key(kp_sat));
	ilh_key_sat #(.KW(KW)) u_sat_s (.cost(cost_secondary), .key(ks_sat));

	assign elem_idx = AW'(elem_q);
	assign rd0_e    = entry_t'(hp_rd0);
	assign rd1_e    = entry_t'(hp_rd1);
	assign left_w   = {hole_q, 1'b1};
	assign right_w  = LW'(left_w) + LW'(1);
	assign left_ok  = LW'(left_w) < LW'(count_q);
	assign right_ok = right_w < LW'(count_q);
	assign parent   = AW'((hole_q - AW'(1)) >> 1);
	assign is_full  = (count_q == CW'(MAX_ELEMENTS));
	assign up_move  = ranks_first(cur_q, rd0_e, min_policy_q);
	assign dn_move  = ranks_first(cdata_q, cur_q, min_policy_q);
	assign pick_right = rvalid_q && ranks_first(rd1_e, rd0_e, min_policy_q);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		hp_we  = 1'b0;
		hp_wa  = hole_q;
		hp_wd  = cur_q;
		hp_ra0 = '0;
		hp_ra1 = '0;
		mk_we  = 1'b0;
		mk_wa  = elem_idx;
		mk_wd  = MARK_WHITE;
		unique case (state_q)
			S_CLR: begin
				mk_we = 1'b1;
				mk_wa = clr_q;
			end
			S_LOOK: begin
				hp_ra0 = AW'(count_q - CW'(1));
			end
			S_DECIDE: begin
				case (mode_q)
					MODE_UPDATE: begin
						if (in_range_q && mk_rd == MARK_WHITE && !is_full) begin
							mk_we = 1'b1;
							mk_wd = MARK_GRAY;
						end
					end
					MODE_REMOVE: begin
						if (count_q != '0) begin
							mk_we = 1'b1;
							mk_wa = AW'(rd1_e.elem);
							mk_wd = MARK_BLACK;
						end
					end
					MODE_DELETE: begin
						if (in_range_q && mk_rd == MARK_GRAY && count_q != '0) begin
							mk_we = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_DREAD: begin
				hp_ra0 = hole_q;
			end
			S_UP: begin
				hp_ra0 = parent;
				hp_we  = (hole_q == '0);
			end
			S_UPCMP: begin
				hp_we = 1'b1;
				if (up_move) begin
					hp_wd = rd0_e;
				end
			end
			S_DOWN: begin
				hp_ra0 = AW'(left_w);
				hp_ra1 = AW'(right_w);
				hp_we  = !left_ok;
			end
			S_DNSW: begin
				hp_we = 1'b1;
				if (dn_move) begin
					hp_wd = cdata_q;
				end
			end
			default: ;
		endcase
	end

	ilh_mem #(.DEPTH(MAX_ELEMENTS), .AW(AW), .HW(HW)) u_mem (
		.clk    (clk),
		.hp_we  (hp_we),
		.hp_wa  (hp_wa),
		.hp_wd  (HW'(hp_wd)),
		.hp_ra0 (hp_ra0),
		.hp_ra1 (hp_ra1),
		.hp_rd0 (hp_rd0),
		.hp_rd1 (hp_rd1),
		.e2s_we (hp_we),
		.e2s_wa (AW'(hp_wd.elem)),
		.e2s_wd (hp_wa),
		.e2s_ra (elem_idx),
		.e2s_rd (e2s_rd),
		.mk_we  (mk_we),
		.mk_wa  (mk_wa),
		.mk_wd  (mk_wd),
		.mk_ra  (elem_idx),
		.mk_rd  (mk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			min_policy_q <= 1'b0;
			count_q      <= '0;
			clr_q        <= '0;
			clr_op_q     <= 1'b0;
			top_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				min_policy_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			if (hp_we && hp_wa == '0) begin
				top_q <= hp_wd.elem;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_ELEMENTS - 1)) begin
						state_q <= clr_op_q ? S_FIN : S_IDLE;
					end
				end
				S_LOOK: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					case (mode_q)
						MODE_UPDATE: begin
							if (!in_range_q || mk_rd == MARK_BLACK) begin
								state_q <= S_FIN;
							end else if (mk_rd == MARK_WHITE) begin
								if (is_full) begin
									state_q <= S_FIN;
								end else begin
									count_q <= count_q + CW'(1);
									state_q <= S_UP;
								end
							end else begin
								state_q <= S_UP;
							end
						end
						MODE_REMOVE: begin
							if (count_q == '0) begin
								state_q <= S_FIN;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= (count_q == CW'(1)) ? S_FIN : S_DOWN;
							end
						end
						MODE_DELETE: begin
							if (!in_range_q || mk_rd != MARK_GRAY || count_q == '0) begin
								state_q <= S_FIN;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= (rd0_e.elem == elem_q) ? S_FIN : S_DREAD;
							end
						end
						default: begin
							count_q  <= '0;
							clr_q    <= '0;
							clr_op_q <= 1'b1;
							state_q  <= S_CLR;
						end
					endcase
				end
				S_DREAD: begin
					state_q <= S_DCMP;
				end
				S_DCMP: begin
					state_q <= ranks_first(rd0_e, cur_q, min_policy_q) ? S_DOWN : S_UP;
				end
				S_UP: begin
					state_q <= (hole_q == '0) ? S_FIN : S_UPCMP;
				end
				S_UPCMP: begin
					state_q <= up_move ? S_UP : S_FIN;
				end
				S_DOWN: begin
					state_q <= left_ok ? S_DNSEL : S_FIN;
				end
				S_DNSEL: begin
					state_q <= S_DNSW;
				end
				S_DNSW: begin
					state_q <= dn_move ? S_DOWN : S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						clr_op_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= mode_t'(mode);
			elem_q     <= element;
			in_range_q <= 32'(element) < MAX_ELEMENTS;
			kp_q       <= kp_sat;
			ks_q       <= ks_sat;
			removed_q  <= '0;
			status_q   <= STAT_OK;
		end
		case (state_q)
			S_DECIDE: begin
				case (mode_q)
					MODE_UPDATE: begin
						cur_q <= '{elem: elem_q, kp: kp_q, ks: ks_q};
						if (!in_range_q || mk_rd == MARK_BLACK) begin
							status_q <= STAT_WRONG;
						end else if (mk_rd == MARK_WHITE) begin
							hole_q <= AW'(count_q);
							if (is_full) begin
								status_q <= STAT_FULL;
							end
						end else begin
							hole_q <= e2s_rd;
						end
					end
					MODE_REMOVE: begin
						cur_q  <= rd0_e;
						hole_q <= '0;
						if (count_q == '0) begin
							status_q <= STAT_EMPTY;
						end else begin
							removed_q <= rd1_e.elem;
						end
					end
					MODE_DELETE: begin
						cur_q  <= rd0_e;
						hole_q <= e2s_rd;
						if (!in_range_q || mk_rd != MARK_GRAY || count_q == '0) begin
							status_q <= STAT_WRONG;
						end
					end
					default: ;
				endcase
			end
			S_UPCMP: begin
				if (up_move) begin
					hole_q <= parent;
				end
			end
			S_DOWN: begin
				left_q   <= AW'(left_w);
				right_q  <= AW'(right_w);
				rvalid_q <= right_ok;
			end
			S_DNSEL: begin
				child_q <= pick_right ? right_q : left_q;
				cdata_q <= pick_right ? rd1_e : rd0_e;
			end
			S_DNSW: begin
				if (dn_move) begin
					hole_q <= child_q;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_removed_q   <= removed_q;
					out_top_q       <= (count_q != '0) ? top_q : '0;
					out_top_valid_q <= (count_q != '0);
					out_full_q      <= is_full;
					out_count_q     <= COUNT_OUT_W'(count_q);
					out_status_q    <= (mode_q == MODE_CLEAR) ? STAT_OK : status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign removed_element = out_removed_q;
	assign top_element     = out_top_q;
	assign top_valid       = out_top_valid_q;
	assign heap_full       = out_full_q;
	assign entry_count     = out_count_q;
	assign status          = out_status_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_ELEMENTS))
		else $error("Queued count exceeds capacity.");

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q == S_LOOK)
		else $error("Accepted word did not start a lookup.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> heap_full)
		else $error("Full status reported while the heap is not full.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> !top_valid && removed_element == '0)
		else $error("Empty status with a valid top or removed word.");

	assert property (@(posedge clk) disable iff (!arst_n)
		hp_we |-> state_q == S_UP || state_q == S_UPCMP || state_q == S_DOWN
			|| state_q == S_DNSW)
		else $error("Slot memory written outside a sift step.");
endmodule
